/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/msm_pkg.sv */
// ----------------------------------------------------------------------------
// msm_pkg
// Types, codes and sizes shared by the string matcher modules.
// ----------------------------------------------------------------------------
package msm_pkg;

  localparam int NODES       = 4096;
  localparam int ALPHABET    = 26;
  localparam int NODE_W      = $clog2(NODES);
  localparam int CNT_W       = $clog2(NODES + 1);
  localparam int SYM_W       = 5;
  localparam int OP_W        = 3;
  localparam int TOT_W       = 16;
  localparam int STAT_W      = 2;
  localparam int CHILD_DEPTH = NODES * ALPHABET;
  localparam int CADDR_W     = $clog2(CHILD_DEPTH);

  // Input op codes
  localparam logic [OP_W-1:0] OP_CLEAR = 3'd0;
  localparam logic [OP_W-1:0] OP_PSYM  = 3'd1;
  localparam logic [OP_W-1:0] OP_PEND  = 3'd2;
  localparam logic [OP_W-1:0] OP_BUILD = 3'd3;
  localparam logic [OP_W-1:0] OP_TSYM  = 3'd4;
  localparam logic [OP_W-1:0] OP_TEND  = 3'd5;

  // Result status codes
  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_OVF   = 2'd1;
  localparam logic [STAT_W-1:0] STAT_EARLY = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [SYM_W-1:0] symbol;
  } in_item_t;

  typedef struct packed {
    logic [TOT_W-1:0]  match_count;
    logic [STAT_W-1:0] status;
  } out_item_t;

  // Datapath micro-operations
  typedef enum logic [4:0] {
    DP_NOP,
    DP_LATCH,
    DP_RESET_REGS,
    DP_ZERO_CHILD,
    DP_INS_RD,
    DP_INS_STEP,
    DP_CNT_RD_INS,
    DP_PEND_FIN,
    DP_BLD_INIT,
    DP_Q_RD,
    DP_U_LOAD,
    DP_RD_UC,
    DP_C_LOAD,
    DP_RD_PC,
    DP_P_STEP,
    DP_LINK_WR,
    DP_S_INC,
    DP_SWP_CLR,
    DP_VIS_CLR,
    DP_BLD_DONE,
    DP_EARLY,
    DP_T_INIT,
    DP_T_STEP,
    DP_VT_RD,
    DP_VT_STEP,
    DP_EMIT
  } dp_cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic sym_ok;
    logic dropped;
    logic built;
    logic child_zero;
    logic pool_full;
    logic p_zero;
    logic u_zero;
    logic s_last;
    logic swp_last;
    logic vis_last;
    logic queue_empty;
    logic vis_set;
    logic out_busy;
  } dp_status_t;

endpackage

/* rtl/msm_ctrl.sv */
// ----------------------------------------------------------------------------
// msm_ctrl
// Sequencer: decodes each transaction and steps the datapath through it.
// ----------------------------------------------------------------------------
module msm_ctrl import msm_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  typedef enum logic [4:0] {
    S_RST, S_ZCHILD, S_IDLE, S_DISP, S_INS_STEP, S_PEND_FIN,
    S_B_POP, S_B_U, S_B_CRD, S_B_CCHK, S_B_PRD, S_B_PCHK, S_B_LINK,
    S_VIS, S_B_DONE, S_T_RD, S_T_CHK, S_T_VIS, S_T_VCHK, S_E_WAIT
  } state_t;

  state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_RST;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

  // Next state and micro-op
  always_comb begin
    state_nxt = state_r;
    cmd       = DP_NOP;
    unique case (state_r)
      S_RST: begin
        cmd       = DP_RESET_REGS;
        state_nxt = S_ZCHILD;
      end
      S_ZCHILD: begin
        cmd = DP_ZERO_CHILD;
        if (status.swp_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd       = DP_LATCH;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        unique case (status.op)
          OP_CLEAR: begin
            cmd       = DP_RESET_REGS;
            state_nxt = S_ZCHILD;
          end
          OP_PSYM: begin
            cmd       = DP_INS_RD;
            state_nxt = (status.sym_ok && !status.dropped) ? S_INS_STEP : S_IDLE;
          end
          OP_PEND: begin
            cmd       = DP_CNT_RD_INS;
            state_nxt = S_PEND_FIN;
          end
          OP_BUILD: begin
            cmd       = DP_BLD_INIT;
            state_nxt = S_B_POP;
          end
          OP_TSYM: begin
            if (!status.built) begin
              cmd       = DP_EARLY;
              state_nxt = S_IDLE;
            end else if (!status.sym_ok) begin
              state_nxt = S_IDLE;
            end else begin
              cmd       = DP_T_INIT;
              state_nxt = S_T_RD;
            end
          end
          OP_TEND: state_nxt = S_E_WAIT;
          default: state_nxt = S_IDLE;
        endcase
      end
      S_INS_STEP: begin
        cmd       = DP_INS_STEP;
        state_nxt = (status.child_zero && !status.pool_full) ? S_ZCHILD : S_IDLE;
      end
      S_PEND_FIN: begin
        cmd       = DP_PEND_FIN;
        state_nxt = S_IDLE;
      end
      // Breadth-first link build
      S_B_POP: begin
        if (status.queue_empty) begin
          cmd       = DP_SWP_CLR;
          state_nxt = S_VIS;
        end else begin
          cmd       = DP_Q_RD;
          state_nxt = S_B_U;
        end
      end
      S_B_U: begin
        cmd       = DP_U_LOAD;
        state_nxt = S_B_CRD;
      end
      S_B_CRD: begin
        cmd       = DP_RD_UC;
        state_nxt = S_B_CCHK;
      end
      S_B_CCHK: begin
        if (status.child_zero) begin
          cmd       = DP_S_INC;
          state_nxt = status.s_last ? S_B_POP : S_B_CRD;
        end else begin
          cmd       = DP_C_LOAD;
          state_nxt = status.u_zero ? S_B_LINK : S_B_PRD;
        end
      end
      S_B_PRD: begin
        cmd       = DP_RD_PC;
        state_nxt = S_B_PCHK;
      end
      S_B_PCHK: begin
        cmd       = DP_P_STEP;
        state_nxt = (!status.child_zero || status.p_zero) ? S_B_LINK : S_B_PRD;
      end
      S_B_LINK: begin
        cmd       = DP_LINK_WR;
        state_nxt = status.s_last ? S_B_POP : S_B_CRD;
      end
      // Visited-mark sweep after build or text end
      S_VIS: begin
        cmd = DP_VIS_CLR;
        if (status.vis_last) state_nxt = (status.op == OP_BUILD) ? S_B_DONE : S_IDLE;
      end
      S_B_DONE: begin
        cmd       = DP_BLD_DONE;
        state_nxt = S_IDLE;
      end
      // Text walk
      S_T_RD: begin
        cmd       = DP_RD_PC;
        state_nxt = S_T_CHK;
      end
      S_T_CHK: begin
        cmd       = DP_T_STEP;
        state_nxt = (!status.p_zero && status.child_zero) ? S_T_RD : S_T_VIS;
      end
      S_T_VIS: begin
        if (status.p_zero) begin
          state_nxt = S_IDLE;
        end else begin
          cmd       = DP_VT_RD;
          state_nxt = S_T_VCHK;
        end
      end
      S_T_VCHK: begin
        if (status.vis_set) begin
          state_nxt = S_IDLE;
        end else begin
          cmd       = DP_VT_STEP;
          state_nxt = S_T_VIS;
        end
      end
      S_E_WAIT: begin
        if (!status.out_busy) begin
          cmd       = DP_EMIT;
          state_nxt = S_VIS;
        end
      end
      default: state_nxt = S_RST;
    endcase
  end

endmodule

/* rtl/msm_datapath.sv */
// ----------------------------------------------------------------------------
// msm_datapath
// Node tables, link queue, cursors, running total and the result register.
// ----------------------------------------------------------------------------
module msm_datapath import msm_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  dp_cmd_t    cmd,
  input  in_item_t   in_data,
  output dp_status_t status,
  output logic       out_valid,
  input  logic       out_stall,
  output out_item_t  out_data
);

  // Memories
  logic [NODE_W-1:0] child_mem [CHILD_DEPTH];
  logic [NODE_W-1:0] fail_mem  [NODES];
  logic [TOT_W-1:0]  cnt_mem   [NODES];
  logic              vis_mem   [NODES];
  logic [NODE_W-1:0] queue_mem [NODES];

  logic [NODE_W-1:0] child_q, fail_q, queue_q;
  logic [TOT_W-1:0]  cnt_q;
  logic              vis_q;

  // Registers
  logic [OP_W-1:0]   op_r;
  logic [SYM_W-1:0]  sym_r, s_r;
  logic [CNT_W-1:0]  nodes_r, head_r, tail_r;
  logic [NODE_W-1:0] ins_r, txt_r, u_r, p_r, c_r, lk_r, swp_r;
  logic [TOT_W-1:0]  tot_r;
  logic              ovf_r, drop_r, built_r, early_r;
  logic              out_valid_r;
  out_item_t         out_r;

  logic [NODE_W-1:0]  new_node, ch_node, f_addr, c_addr, v_addr;
  logic [SYM_W-1:0]   ch_sym;
  logic [CADDR_W-1:0] ch_addr;
  logic               create, pend_ok;
  logic [TOT_W:0]     sum;
  logic [TOT_W-1:0]   cnt_inc;
  logic [STAT_W-1:0]  stat_code;

  assign new_node = nodes_r[NODE_W-1:0];
  assign create   = (child_q == '0) && (nodes_r != CNT_W'(NODES));
  assign pend_ok  = !drop_r && (ins_r != '0);
  assign sum      = {1'b0, tot_r} + {1'b0, cnt_q};
  assign cnt_inc  = (cnt_q == {TOT_W{1'b1}}) ? cnt_q : cnt_q + TOT_W'(1);
  assign stat_code = ovf_r ? STAT_OVF : ((early_r || !built_r) ? STAT_EARLY : STAT_OK);

  // Address selection
  always_comb begin
    case (cmd)
      DP_ZERO_CHILD:          begin ch_node = u_r;   ch_sym = swp_r[SYM_W-1:0]; end
      DP_INS_RD, DP_INS_STEP: begin ch_node = ins_r; ch_sym = sym_r; end
      DP_RD_UC:               begin ch_node = u_r;   ch_sym = s_r; end
      default:                begin ch_node = p_r;   ch_sym = s_r; end
    endcase
    case (cmd)
      DP_RD_UC:                 f_addr = u_r;
      DP_INS_STEP:              f_addr = new_node;
      DP_RESET_REGS, DP_BLD_INIT: f_addr = '0;
      DP_LINK_WR:               f_addr = c_r;
      default:                  f_addr = p_r;
    endcase
    case (cmd)
      DP_INS_STEP:                 c_addr = new_node;
      DP_RESET_REGS:               c_addr = '0;
      DP_CNT_RD_INS, DP_PEND_FIN:  c_addr = ins_r;
      default:                     c_addr = p_r;
    endcase
    case (cmd)
      DP_INS_STEP:   v_addr = new_node;
      DP_RESET_REGS: v_addr = '0;
      DP_VIS_CLR:    v_addr = swp_r;
      default:       v_addr = p_r;
    endcase
  end

  assign ch_addr = CADDR_W'(ch_node) * CADDR_W'(ALPHABET) + CADDR_W'(ch_sym);

  // Child table
  always_ff @(posedge clk) begin
    if (cmd == DP_ZERO_CHILD) begin
      child_mem[ch_addr] <= '0;
    end else if (cmd == DP_INS_STEP && create) begin
      child_mem[ch_addr] <= new_node;
    end
    if (cmd == DP_INS_RD || cmd == DP_RD_UC || cmd == DP_RD_PC) begin
      child_q <= child_mem[ch_addr];
    end
  end

  // Failure links
  always_ff @(posedge clk) begin
    if ((cmd == DP_INS_STEP && create) || cmd == DP_RESET_REGS || cmd == DP_BLD_INIT) begin
      fail_mem[f_addr] <= '0;
    end else if (cmd == DP_LINK_WR) begin
      fail_mem[f_addr] <= lk_r;
    end
    if (cmd == DP_RD_UC || cmd == DP_RD_PC || cmd == DP_VT_RD) begin
      fail_q <= fail_mem[f_addr];
    end
  end

  // Pattern counts
  always_ff @(posedge clk) begin
    if ((cmd == DP_INS_STEP && create) || cmd == DP_RESET_REGS) begin
      cnt_mem[c_addr] <= '0;
    end else if (cmd == DP_PEND_FIN && pend_ok) begin
      cnt_mem[c_addr] <= cnt_inc;
    end
    if (cmd == DP_CNT_RD_INS || cmd == DP_VT_RD) begin
      cnt_q <= cnt_mem[c_addr];
    end
  end

  // Visited marks
  always_ff @(posedge clk) begin
    if ((cmd == DP_INS_STEP && create) || cmd == DP_RESET_REGS || cmd == DP_VIS_CLR) begin
      vis_mem[v_addr] <= 1'b0;
    end else if (cmd == DP_VT_STEP) begin
      vis_mem[v_addr] <= 1'b1;
    end
    if (cmd == DP_VT_RD) begin
      vis_q <= vis_mem[v_addr];
    end
  end

  // Breadth-first queue
  always_ff @(posedge clk) begin
    if (cmd == DP_BLD_INIT) begin
      queue_mem[0] <= '0;
    end else if (cmd == DP_LINK_WR) begin
      queue_mem[tail_r[NODE_W-1:0]] <= c_r;
    end
    if (cmd == DP_Q_RD) begin
      queue_q <= queue_mem[head_r[NODE_W-1:0]];
    end
  end

  // Control and cursor registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nodes_r     <= CNT_W'(1);
      ins_r       <= '0;
      txt_r       <= '0;
      tot_r       <= '0;
      ovf_r       <= 1'b0;
      drop_r      <= 1'b0;
      built_r     <= 1'b0;
      early_r     <= 1'b0;
      out_valid_r <= 1'b0;
      swp_r       <= '0;
      u_r         <= '0;
    end else begin
      // Result valid: set on emit, dropped once taken
      if (cmd == DP_EMIT) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
      case (cmd)
        DP_LATCH: begin
          op_r  <= in_data.op;
          sym_r <= in_data.symbol;
        end
        DP_RESET_REGS: begin
          nodes_r <= CNT_W'(1);
          ins_r   <= '0;
          txt_r   <= '0;
          tot_r   <= '0;
          ovf_r   <= 1'b0;
          drop_r  <= 1'b0;
          built_r <= 1'b0;
          early_r <= 1'b0;
          u_r     <= '0;
          swp_r   <= '0;
        end
        DP_ZERO_CHILD: swp_r <= swp_r + NODE_W'(1);
        DP_INS_RD:     built_r <= 1'b0;
        DP_INS_STEP: begin
          if (child_q != '0) begin
            ins_r <= child_q;
          end else if (!create) begin
            ovf_r  <= 1'b1;
            drop_r <= 1'b1;
          end else begin
            ins_r   <= new_node;
            u_r     <= new_node;
            nodes_r <= nodes_r + CNT_W'(1);
            swp_r   <= '0;
          end
        end
        DP_CNT_RD_INS: built_r <= 1'b0;
        DP_PEND_FIN: begin
          drop_r <= 1'b0;
          ins_r  <= '0;
        end
        DP_BLD_INIT: begin
          head_r <= '0;
          tail_r <= CNT_W'(1);
        end
        DP_Q_RD: head_r <= head_r + CNT_W'(1);
        DP_U_LOAD: begin
          u_r <= queue_q;
          s_r <= '0;
        end
        DP_C_LOAD: begin
          c_r  <= child_q;
          p_r  <= fail_q;
          lk_r <= '0;
        end
        DP_P_STEP: begin
          if (child_q != '0) lk_r <= child_q;
          else               p_r  <= fail_q;
        end
        DP_LINK_WR: begin
          tail_r <= tail_r + CNT_W'(1);
          s_r    <= s_r + SYM_W'(1);
        end
        DP_S_INC:   s_r   <= s_r + SYM_W'(1);
        DP_SWP_CLR: swp_r <= '0;
        DP_VIS_CLR: swp_r <= swp_r + NODE_W'(1);
        DP_BLD_DONE: begin
          built_r <= 1'b1;
          txt_r   <= '0;
          tot_r   <= '0;
        end
        DP_EARLY: early_r <= 1'b1;
        DP_T_INIT: begin
          p_r <= txt_r;
          s_r <= sym_r;
        end
        DP_T_STEP: begin
          if (p_r != '0 && child_q == '0) begin
            p_r <= fail_q;
          end else begin
            p_r   <= child_q;
            txt_r <= child_q;
          end
        end
        DP_VT_STEP: begin
          tot_r <= sum[TOT_W] ? {TOT_W{1'b1}} : sum[TOT_W-1:0];
          p_r   <= fail_q;
        end
        DP_EMIT: begin
          out_r.match_count <= tot_r;
          out_r.status      <= stat_code;
          tot_r             <= '0;
          txt_r             <= '0;
          early_r           <= 1'b0;
          swp_r             <= '0;
        end
        default: ;
      endcase
    end
  end

  // Status to the sequencer
  always_comb begin
    status.op          = op_r;
    status.sym_ok      = (sym_r < SYM_W'(ALPHABET));
    status.dropped     = drop_r;
    status.built       = built_r;
    status.child_zero  = (child_q == '0);
    status.pool_full   = (nodes_r == CNT_W'(NODES));
    status.p_zero      = (p_r == '0);
    status.u_zero      = (u_r == '0);
    status.s_last      = (s_r == SYM_W'(ALPHABET - 1));
    status.swp_last    = (swp_r == NODE_W'(ALPHABET - 1));
    status.vis_last    = ((CNT_W'(swp_r) + CNT_W'(1)) == nodes_r);
    status.queue_empty = (head_r == tail_r);
    status.vis_set     = vis_q;
    status.out_busy    = out_valid_r && out_stall;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

/* rtl/multi_pattern_string_matcher.sv */
// ----------------------------------------------------------------------------
// multi_pattern_string_matcher
// Multi-pattern string matcher: trie build, failure links, text scan.
// ----------------------------------------------------------------------------
// Input channel in_valid/in_stall/in_data carries one op per transaction:
// clear, pattern symbol, pattern end, build links, text symbol, text end.
// Only text end yields a transaction on out_valid/out_stall/out_data with
// the saturated match count and a status code.
// One op at a time; in_stall stays high while an op is being worked.
// A pattern symbol that adds a node zeroes that node's 26 child slots; a
// text symbol follows failure hops and then marks newly visited nodes;
// build walks every child slot of every node and searches a link per
// child; build and text end both finish with a mark sweep over the
// used nodes.
// The child table is single-port; slot zeroing and the visited-mark
// sweep handle one entry per cycle.
// After reset (and after a clear op) the root's child slots are zeroed
// with in_stall high.
// The result sits in an output register; a stalled result holds, and a
// following text end waits until it is taken, other ops proceed.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module multi_pattern_string_matcher import msm_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  dp_cmd_t    cmd;
  dp_status_t status;

  msm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  msm_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_data   (in_data),
    .status    (status),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // Checks
  `ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "accepted op not held")
  `ASSERT_IMPL(a_no_overwrite, cmd == DP_EMIT, !(out_valid && out_stall), "pending result lost")
  `ASSERT_IMPL(a_result_from_emit, $rose(out_valid), $past(cmd == DP_EMIT), "spurious result")

endmodule

/* sim/multi_pattern_string_matcher_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// multi_pattern_string_matcher_tb
// Self-checking bench for the multi-pattern string matcher. A local trie and
// failure-link model predicts the count and status of every text end; the
// monitor compares each result transaction against the oldest prediction.
// Stimulus runs a directed pass, a node pool overflow pass, random
// dictionary/text sessions under several idle and stall mixes, and a long
// receiver hold-off that backs the block up.
// ----------------------------------------------------------------------------
module multi_pattern_string_matcher_tb;
  import msm_pkg::*;

  // Unused op codes, ignored by the block
  localparam logic [OP_W-1:0] OP_SPARE6 = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE7 = 3'd7;
  localparam int WATCHDOG_LIMIT = 50000;
  localparam int HOLD_CYCLES    = 2000;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;

  multi_pattern_string_matcher DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  in_item_t  pending_ops[$];
  out_item_t expected_counts[$];
  int        error_count = 0;
  int        send_idle_pct = 0;
  int        recv_stall_pct = 0;
  int        hold_left = 0;
  int        quiet_cycles = 0;

  // Shadow automaton
  int unsigned trie_child[NODES*ALPHABET];
  int unsigned fail_link[NODES];
  int unsigned pat_count[NODES];
  bit          visited[NODES];
  int unsigned nodes_used, ins_node, txt_node, total;
  bit          ovf_flag, dropped, built, early;

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  task automatic report(string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    error_count++;
  endtask

  function automatic void init_node(int unsigned n);
    for (int s = 0; s < ALPHABET; s++) trie_child[n*ALPHABET + s] = 0;
    fail_link[n] = 0;
    pat_count[n] = 0;
    visited[n] = 0;
  endfunction

  function automatic void clear_visits();
    for (int i = 0; i < nodes_used; i++) visited[i] = 0;
  endfunction

  function automatic void dict_reset();
    nodes_used = 1;
    init_node(0);
    ins_node = 0; txt_node = 0; total = 0;
    ovf_flag = 0; dropped = 0; built = 0; early = 0;
  endfunction

  // Breadth-first failure link fill
  function automatic void build_links();
    int unsigned bfs[$];
    int unsigned u, c, p, n, link;
    bfs.push_back(0);
    fail_link[0] = 0;
    while (bfs.size() > 0) begin
      u = bfs.pop_front();
      for (int s = 0; s < ALPHABET; s++) begin
        c = trie_child[u*ALPHABET + s];
        if (c == 0) continue;
        link = 0;
        if (u != 0) begin
          p = fail_link[u];
          forever begin
            n = trie_child[p*ALPHABET + s];
            if (n != 0) begin
              link = n;
              break;
            end
            if (p == 0) break;
            p = fail_link[p];
          end
        end
        fail_link[c] = link;
        bfs.push_back(c);
      end
    end
    clear_visits();
    built = 1; txt_node = 0; total = 0;
  endfunction

  function automatic void scan_symbol(int unsigned s);
    int unsigned p, t;
    p = txt_node;
    while (p != 0 && trie_child[p*ALPHABET + s] == 0) p = fail_link[p];
    p = trie_child[p*ALPHABET + s];
    txt_node = p;
    t = p;
    while (t != 0 && !visited[t]) begin
      total += pat_count[t];
      if (total > 65535) total = 65535;
      visited[t] = 1;
      t = fail_link[t];
    end
  endfunction

  // Advance the shadow automaton by one accepted transaction
  function automatic void predict_match(in_item_t it);
    out_item_t res;
    int unsigned c;
    case (it.op)
      OP_CLEAR: dict_reset();
      OP_PSYM: begin
        built = 0;
        if (it.symbol < ALPHABET && !dropped) begin
          c = trie_child[ins_node*ALPHABET + it.symbol];
          if (c == 0 && nodes_used >= NODES) begin
            ovf_flag = 1;
            dropped = 1;
          end else begin
            if (c == 0) begin
              c = nodes_used++;
              init_node(c);
              trie_child[ins_node*ALPHABET + it.symbol] = c;
            end
            ins_node = c;
          end
        end
      end
      OP_PEND: begin
        built = 0;
        if (!dropped && ins_node != 0 && pat_count[ins_node] < 65535)
          pat_count[ins_node]++;
        dropped = 0;
        ins_node = 0;
      end
      OP_BUILD: build_links();
      OP_TSYM: begin
        if (!built) early = 1;
        else if (it.symbol < ALPHABET) scan_symbol(it.symbol);
      end
      OP_TEND: begin
        if (!built) early = 1;
        res.match_count = total[15:0];
        res.status = ovf_flag ? STAT_OVF : (early ? STAT_EARLY : STAT_OK);
        expected_counts.push_back(res);
        total = 0; txt_node = 0; early = 0;
        clear_visits();
      end
      default: ;
    endcase
  endfunction

  // Driver: feeds pending ops, holds a stalled transaction
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data  <= '0;
    end else begin
      if (in_valid && !in_stall) predict_match(in_data);
      if (!(in_valid && in_stall)) begin
        if (pending_ops.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_data  <= pending_ops.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: result checks and receiver stall
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_counts.size() == 0) begin
          report($sformatf("unexpected result count=%0d status=%0d",
                           out_data.match_count, out_data.status));
        end else begin
          if (out_data.match_count !== expected_counts[0].match_count)
            report($sformatf("match_count got %0d exp %0d",
                             out_data.match_count, expected_counts[0].match_count));
          if (out_data.status !== expected_counts[0].status)
            report($sformatf("status got %0d exp %0d",
                             out_data.status, expected_counts[0].status));
          void'(expected_counts.pop_front());
        end
      end
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  // Watchdog on cycles without any accepted transaction
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Watchdog expired after %0d idle cycles", quiet_cycles);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  task automatic push_op(logic [OP_W-1:0] op, logic [SYM_W-1:0] sym);
    in_item_t it;
    it.op = op;
    it.symbol = sym;
    pending_ops.push_back(it);
  endtask

  task automatic drain();
    while (pending_ops.size() > 0 || in_valid || expected_counts.size() > 0)
      @(posedge clk);
  endtask

  function automatic logic [SYM_W-1:0] pick_symbol();
    int r;
    r = $urandom_range(99);
    if (r < 80) return SYM_W'($urandom_range(3));
    if (r < 95) return SYM_W'($urandom_range(ALPHABET - 1));
    return SYM_W'($urandom_range(31));
  endfunction

  // One random session: dictionary, usually a build, several texts, with some noise
  task automatic random_session();
    int len;
    if ($urandom_range(99) < 30) push_op(OP_CLEAR, SYM_W'($urandom_range(31)));
    repeat ($urandom_range(6, 1)) begin
      len = $urandom_range(5);
      repeat (len) push_op(OP_PSYM, pick_symbol());
      push_op(OP_PEND, SYM_W'($urandom_range(31)));
    end
    if ($urandom_range(99) < 90) push_op(OP_BUILD, SYM_W'($urandom_range(31)));
    repeat ($urandom_range(3, 1)) begin
      repeat ($urandom_range(15)) push_op(OP_TSYM, pick_symbol());
      if ($urandom_range(99) < 10)
        push_op(OP_W'($urandom_range(7)), SYM_W'($urandom_range(31)));
      push_op(OP_TEND, SYM_W'($urandom_range(31)));
    end
  endtask

  task automatic random_phase(int n_items, int idle_pct, int stall_pct);
    int start;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    start = pending_ops.size();
    while (pending_ops.size() - start < n_items) random_session();
    drain();
  endtask

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    out_stall = 1'b0;
    dict_reset();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: early text, empty pattern, duplicates, bad symbols, spare ops
    push_op(OP_TSYM, 5'd0);
    push_op(OP_TEND, 5'd0);
    push_op(OP_PEND, 5'd0);
    push_op(OP_PSYM, 5'd0);
    push_op(OP_PEND, 5'd0);
    push_op(OP_PSYM, 5'd0);
    push_op(OP_PEND, 5'd0);
    push_op(OP_PSYM, 5'd0);
    push_op(OP_PSYM, 5'd31);
    push_op(OP_PSYM, 5'd25);
    push_op(OP_PEND, 5'd0);
    push_op(OP_PSYM, 5'd25);
    push_op(OP_PEND, 5'd31);
    push_op(OP_SPARE6, 5'd3);
    push_op(OP_SPARE7, 5'd31);
    push_op(OP_BUILD, 5'd0);
    push_op(OP_TSYM, 5'd0);
    push_op(OP_TSYM, 5'd26);
    push_op(OP_TSYM, 5'd25);
    push_op(OP_TSYM, 5'd0);
    push_op(OP_TEND, 5'd0);
    push_op(OP_PSYM, 5'd1);
    push_op(OP_TEND, 5'd0);
    push_op(OP_CLEAR, 5'd0);
    push_op(OP_TEND, 5'd0);
    drain();

    // Pool overflow: one long chain past the node limit
    for (int i = 0; i < NODES + 4; i++) push_op(OP_PSYM, 5'(i % 2));
    push_op(OP_PEND, 5'd0);
    push_op(OP_TSYM, 5'd0);
    push_op(OP_TEND, 5'd0);
    push_op(OP_CLEAR, 5'd0);
    push_op(OP_TEND, 5'd0);
    drain();

    // Random sessions under several idle and stall mixes
    random_phase(220, 0, 0);
    random_phase(210, 76, 0);
    random_phase(210, 0, 76);
    random_phase(210, 7, 7);

    // Long receiver hold-off while text ends keep coming
    hold_left = HOLD_CYCLES;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    push_op(OP_PSYM, 5'd2);
    push_op(OP_PEND, 5'd0);
    push_op(OP_BUILD, 5'd0);
    repeat (6) begin
      push_op(OP_TSYM, 5'd2);
      push_op(OP_TEND, 5'd0);
    end
    drain();

    repeat (200) @(posedge clk);
    while (expected_counts.size() > 0) begin
      report("expected result never arrived");
      void'(expected_counts.pop_front());
    end
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
